>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define MPBM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define MPBM_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/core/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// types and constants for the multi-pattern byte matcher
// ----------------------------------------------------------------------------
package mpbm_pkg;

  localparam int MAX_NODES = 256;
  localparam int NODE_W    = 8;
  localparam int BYTE_W    = 8;
  localparam int ALPHABET  = 256;
  localparam int CNT_W     = 9;
  localparam int TT_AW     = NODE_W + BYTE_W;
  localparam int TT_DEPTH  = MAX_NODES * ALPHABET;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_SCAN   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_PHASE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              region_start;
  } in_item_t;

  typedef struct packed {
    logic             matched;
    logic [1:0]       status;
    logic [CNT_W-1:0] node_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_INS_CHK,
    ST_ROWCLR,
    ST_INS_FIN,
    ST_B0_RD,
    ST_B0_CK,
    ST_B_POP,
    ST_B_X,
    ST_B_F,
    ST_B_A,
    ST_B_C1,
    ST_B_C2,
    ST_B_C3,
    ST_S_RD,
    ST_S_AC
  } state_t;

endpackage

>>> rtl/core/mpbm_ram.sv
// ----------------------------------------------------------------------------
// mpbm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/multi_pattern_byte_matcher_core.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_core
// aho-corasick style byte matcher: trie insert, breadth-first build, scan
// ----------------------------------------------------------------------------
// One item is handled at a time; in_ready is high only while idle. All work
// runs through a transition memory (256 nodes x 256 bytes) with one write
// and one registered read port, beside failure-link, queue and accept-flag
// memories, under a small sequencer. An insert that allocates a node sweeps
// that node's row to zero; clear sweeps the root row, and build walks the
// root row and then each non-root node's row in breadth-first order. After
// reset the root row is swept before the first item is taken.
// A finished result waits in the output register without blocking the next
// item; a result that finds that register still full holds the sequencer in ST_S_AC until it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_pattern_byte_matcher_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mpbm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mpbm_pkg::out_item_t out_item
);
  import mpbm_pkg::*;

  localparam logic [BYTE_W-1:0] BYTE_LAST = {BYTE_W{1'b1}};

  state_t              state_r, state_nxt;
  in_item_t            item_r, item_nxt;
  logic [CNT_W-1:0]    nodes_used_r, nodes_used_nxt;
  logic [NODE_W-1:0]   ins_pos_r, ins_pos_nxt;
  logic                dropped_r, dropped_nxt;
  logic [NODE_W-1:0]   scan_pos_r, scan_pos_nxt;
  logic                built_r, built_nxt;
  logic [NODE_W-1:0]   head_r, head_nxt;
  logic [NODE_W-1:0]   tail_r, tail_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;
  logic [NODE_W-1:0]   x_r, x_nxt;
  logic [NODE_W-1:0]   f_r, f_nxt;
  logic [NODE_W-1:0]   ch_r, ch_nxt;
  logic                reply_r, reply_nxt;
  logic                res_match_r, res_match_nxt;
  status_t             res_stat_r, res_stat_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  // memory ports
  logic              tt_we;
  logic [TT_AW-1:0]  tt_waddr, tt_raddr;
  logic [NODE_W-1:0] tt_wdata, tt_rdata;
  logic              fl_we;
  logic [NODE_W-1:0] fl_waddr, fl_wdata, fl_raddr, fl_rdata;
  logic              q_we;
  logic [NODE_W-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
  logic              ac_we;
  logic [NODE_W-1:0] ac_waddr, ac_raddr;
  logic              ac_wdata, ac_rdata;

  // transition table, node by byte
  mpbm_ram #(.WIDTH(NODE_W), .DEPTH(TT_DEPTH)) u_tt (
    .clk(clk), .we(tt_we), .waddr(tt_waddr), .wdata(tt_wdata),
    .raddr(tt_raddr), .rdata(tt_rdata)
  );

  // failure links
  mpbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fl (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );

  // breadth-first queue
  mpbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // accept flags, cleared when a node is allocated
  mpbm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_ac (
    .clk(clk), .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
    .raddr(ac_raddr), .rdata(ac_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      nodes_used_r <= CNT_W'(1);
      ins_pos_r    <= '0;
      dropped_r    <= 1'b0;
      scan_pos_r   <= '0;
      built_r      <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      byte_r       <= '0;
      reply_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
      ins_pos_r    <= ins_pos_nxt;
      dropped_r    <= dropped_nxt;
      scan_pos_r   <= scan_pos_nxt;
      built_r      <= built_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      byte_r       <= byte_nxt;
      reply_r      <= reply_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    x_r         <= x_nxt;
    f_r         <= f_nxt;
    ch_r        <= ch_nxt;
    res_match_r <= res_match_nxt;
    res_stat_r  <= res_stat_nxt;
    out_item_r  <= out_item_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    nodes_used_nxt = nodes_used_r;
    ins_pos_nxt    = ins_pos_r;
    dropped_nxt    = dropped_r;
    scan_pos_nxt   = scan_pos_r;
    built_nxt      = built_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    byte_nxt       = byte_r;
    x_nxt          = x_r;
    f_nxt          = f_r;
    ch_nxt         = ch_r;
    reply_nxt      = reply_r;
    res_match_nxt  = res_match_r;
    res_stat_nxt   = res_stat_r;
    out_item_nxt   = out_item_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    tt_we = 1'b0; tt_waddr = '0; tt_wdata = '0; tt_raddr = '0;
    fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0; fl_raddr = '0;
    q_we  = 1'b0; q_waddr  = '0; q_wdata  = '0; q_raddr  = '0;
    ac_we = 1'b0; ac_waddr = '0; ac_wdata = 1'b0; ac_raddr = '0;

    case (state_r)
      // take an item and start its command
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt      = in_item;
          res_match_nxt = 1'b0;
          res_stat_nxt  = STAT_OK;
          case (in_item.command)
            CMD_INSERT: begin
              if (built_r) begin
                res_stat_nxt = STAT_PHASE;
                state_nxt    = ST_S_AC;
              end else if (dropped_r) begin
                res_stat_nxt = STAT_FULL;
                if (in_item.last_byte) begin
                  dropped_nxt = 1'b0;
                  ins_pos_nxt = '0;
                end
                state_nxt = ST_S_AC;
              end else begin
                tt_raddr  = {ins_pos_r, in_item.data_byte};
                state_nxt = ST_INS_CHK;
              end
            end
            CMD_BUILD: begin
              if (built_r) begin
                res_stat_nxt = STAT_PHASE;
                state_nxt    = ST_S_AC;
              end else begin
                byte_nxt  = '0;
                head_nxt  = '0;
                tail_nxt  = '0;
                state_nxt = ST_B0_RD;
              end
            end
            CMD_SCAN: begin
              if (!built_r) begin
                res_stat_nxt = STAT_PHASE;
                state_nxt    = ST_S_AC;
              end else begin
                tt_raddr  = {(in_item.region_start ? {NODE_W{1'b0}} : scan_pos_r),
                             in_item.data_byte};
                state_nxt = ST_S_RD;
              end
            end
            default: begin
              nodes_used_nxt = CNT_W'(1);
              ins_pos_nxt    = '0;
              dropped_nxt    = 1'b0;
              scan_pos_nxt   = '0;
              built_nxt      = 1'b0;
              head_nxt       = '0;
              tail_nxt       = '0;
              byte_nxt       = '0;
              reply_nxt      = 1'b1;
              state_nxt      = ST_CLR;
            end
          endcase
        end
      end

      // sweep the root row to zero
      ST_CLR: begin
        tt_we    = 1'b1;
        tt_waddr = {{NODE_W{1'b0}}, byte_r};
        if (byte_r == '0) begin
          ac_we = 1'b1;
        end
        byte_nxt = byte_r + 1'b1;
        if (byte_r == BYTE_LAST) begin
          reply_nxt     = 1'b0;
          res_match_nxt = 1'b0;
          res_stat_nxt  = STAT_OK;
          state_nxt     = reply_r ? ST_S_AC : ST_IDLE;
        end
      end

      // insert: look at the child slot
      ST_INS_CHK: begin
        if (tt_rdata == '0) begin
          if (nodes_used_r >= CNT_W'(MAX_NODES)) begin
            res_stat_nxt = STAT_FULL;
            if (item_r.last_byte) begin
              ins_pos_nxt = '0;
            end else begin
              dropped_nxt = 1'b1;
            end
            state_nxt = ST_S_AC;
          end else begin
            ch_nxt         = nodes_used_r[NODE_W-1:0];
            tt_we          = 1'b1;
            tt_waddr       = {ins_pos_r, item_r.data_byte};
            tt_wdata       = nodes_used_r[NODE_W-1:0];
            nodes_used_nxt = nodes_used_r + 1'b1;
            byte_nxt       = '0;
            state_nxt      = ST_ROWCLR;
          end
        end else begin
          ch_nxt    = tt_rdata;
          state_nxt = ST_INS_FIN;
        end
      end

      // fresh node: zero its row and its accept flag
      ST_ROWCLR: begin
        tt_we    = 1'b1;
        tt_waddr = {ch_r, byte_r};
        if (byte_r == '0) begin
          ac_we    = 1'b1;
          ac_waddr = ch_r;
        end
        byte_nxt = byte_r + 1'b1;
        if (byte_r == BYTE_LAST) begin
          state_nxt = ST_INS_FIN;
        end
      end

      // insert: advance or close the pattern
      ST_INS_FIN: begin
        if (item_r.last_byte) begin
          ac_we       = 1'b1;
          ac_waddr    = ch_r;
          ac_wdata    = 1'b1;
          ins_pos_nxt = '0;
        end else begin
          ins_pos_nxt = ch_r;
        end
        state_nxt = ST_S_AC;
      end

      // build: read a root child
      ST_B0_RD: begin
        tt_raddr  = {{NODE_W{1'b0}}, byte_r};
        state_nxt = ST_B0_CK;
      end

      // build: queue a root child with failure link to root
      ST_B0_CK: begin
        if (tt_rdata != '0) begin
          fl_we    = 1'b1;
          fl_waddr = tt_rdata;
          q_we     = 1'b1;
          q_waddr  = tail_r;
          q_wdata  = tt_rdata;
          tail_nxt = tail_r + 1'b1;
        end
        byte_nxt  = byte_r + 1'b1;
        state_nxt = (byte_r == BYTE_LAST) ? ST_B_POP : ST_B0_RD;
      end

      // build: next node from the queue, or finish
      ST_B_POP: begin
        if (head_r == tail_r) begin
          built_nxt    = 1'b1;
          ins_pos_nxt  = '0;
          dropped_nxt  = 1'b0;
          scan_pos_nxt = '0;
          state_nxt    = ST_S_AC;
        end else begin
          q_raddr   = head_r;
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_B_X;
        end
      end

      ST_B_X: begin
        x_nxt     = q_rdata;
        fl_raddr  = q_rdata;
        state_nxt = ST_B_F;
      end

      ST_B_F: begin
        f_nxt     = fl_rdata;
        ac_raddr  = fl_rdata;
        state_nxt = ST_B_A;
      end

      // inherit accept from the failure node
      ST_B_A: begin
        if (ac_rdata) begin
          ac_we    = 1'b1;
          ac_waddr = x_r;
          ac_wdata = 1'b1;
        end
        byte_nxt  = '0;
        state_nxt = ST_B_C1;
      end

      ST_B_C1: begin
        tt_raddr  = {x_r, byte_r};
        state_nxt = ST_B_C2;
      end

      ST_B_C2: begin
        ch_nxt    = tt_rdata;
        tt_raddr  = {f_r, byte_r};
        state_nxt = ST_B_C3;
      end

      // fill the missing transition or queue the child
      ST_B_C3: begin
        if (ch_r == '0) begin
          tt_we    = 1'b1;
          tt_waddr = {x_r, byte_r};
          tt_wdata = tt_rdata;
        end else begin
          fl_we    = 1'b1;
          fl_waddr = ch_r;
          fl_wdata = tt_rdata;
          q_we     = 1'b1;
          q_waddr  = tail_r;
          q_wdata  = ch_r;
          tail_nxt = tail_r + 1'b1;
        end
        byte_nxt  = byte_r + 1'b1;
        state_nxt = (byte_r == BYTE_LAST) ? ST_B_POP : ST_B_C1;
      end

      // scan: step the automaton
      ST_S_RD: begin
        scan_pos_nxt = tt_rdata;
        ac_raddr     = tt_rdata;
        state_nxt    = ST_S_AC;
        res_match_nxt = 1'b1;
      end

      // hand the result to the output register
      ST_S_AC: begin
        // keep the accept flag of the new scan state on the read port
        ac_raddr = scan_pos_r;
        if (!out_valid_r || out_ready) begin
          out_item_nxt.matched    = res_match_r && ac_rdata;
          out_item_nxt.status     = res_stat_r;
          out_item_nxt.node_count = nodes_used_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // a taken item always keeps the block busy for the next cycle
  `MPBM_ASSERT(a_busy_after_take, (in_valid && in_ready) |=> !in_ready)
  // node count stays between root only and a full table
  `MPBM_NEVER(a_nodes_range, nodes_used_r == '0 || nodes_used_r > CNT_W'(MAX_NODES))
  // scan steps only run on a built automaton
  `MPBM_ASSERT(a_scan_built, (state_r == ST_S_RD) |-> built_r)

endmodule
